### rtl/mptk_pkg.sv
// Shared types and constants for the k-trade maximum profit block.
`default_nettype none

package mptk_pkg;

   // Fixed field widths.
   localparam int PRICE_W  = 24;
   localparam int TRADES_W = 11;
   localparam int VALUE_W  = 48;
   localparam int PROFIT_W = 40;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_WAIT_ZERO,
      ST_CHECK,
      ST_WAIT_MID,
      ST_WAIT_LOW,
      ST_MUL,
      ST_SUM
   } state_type;

   typedef enum logic [1:0] {
      PEN_ZERO,
      PEN_MID,
      PEN_LOW
   } pen_mode_type;

   typedef struct packed {
      logic         store_write;
      logic         count_clear;
      logic         pass_start;
      pen_mode_type pen_mode;
      logic         search_init;
      logic         bound_update;
      logic         result_zero;
      logic         mul;
      logic         sum;
   } cmd_type;

   typedef struct packed {
      logic pass_done;
      logic fits;
      logic search_open;
   } status_type;

endpackage

`default_nettype wire

### rtl/max_profit_k_trades.sv
// Use of the block:
// Prices arrive on the req_ channel, one item per cycle while loading; the
// item with req_last_price high is itself a price and closes the series.
// Up to MAX_PRICES prices are kept; further prices are dropped, though a last
// flag on such an item still starts the computation.
// After the last item the block runs penalised DP passes over the store, one
// price per cycle, each pass also filling the registered read pipeline. One pass
// settles the result when the unpenalised trade count fits max_trades;
// otherwise a binary search over the penalty takes up to ceil(log2(PENALTY_MAX+1))
// passes and one more pass follows at the found penalty, then a multiply step
// and an add step. With the default PENALTY_MAX that is up to 26 passes, each
// reading every stored price once through the single store read port.
// The result appears on rsp_ and is held until rsp_ready takes it. Prices of
// the next series are accepted meanwhile; only its last item waits.
// max_trades is to be written through csr_ only while the block is idle; the block
// does not enforce this, and csr_ready is always high. Reset empties the series,
// sets max_trades to 1 and drops any pending result.
`default_nettype none

module max_profit_k_trades
   import mptk_pkg::*;
#(
   parameter int MAX_PRICES  = 1024,
   parameter int PENALTY_MAX = 10000000
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic [PRICE_W-1:0]  req_price,
   input  wire logic                req_last_price,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic [PROFIT_W-1:0]      rsp_best_profit,
   input  wire logic                csr_valid,
   output logic                     csr_ready,
   input  wire logic [TRADES_W-1:0] csr_max_trades
);

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   mptk_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_last_price (req_last_price),
      .req_ready      (req_ready),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .status         (status),
      .cmd            (cmd)
   );

   mptk_dpath #(
      .MAX_PRICES  (MAX_PRICES),
      .PENALTY_MAX (PENALTY_MAX)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .req_price       (req_price),
      .csr_write       (csr_valid && csr_ready),
      .csr_max_trades  (csr_max_trades),
      .cmd             (cmd),
      .status          (status),
      .rsp_best_profit (rsp_best_profit)
   );

endmodule

`default_nettype wire

### rtl/mptk_ctrl.sv
// Sequencer for loading, penalised passes, the penalty search and the result.
`default_nettype none

module mptk_ctrl
   import mptk_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   input  wire logic       req_last_price,
   output logic            req_ready,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   input  wire status_type status,
   output cmd_type         cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // A last item waits while the previous result has not been taken,
   // because the result register is reused by the next computation.
   assign req_ready = (state_ff == ST_LOAD) && !(rsp_valid_ff && req_last_price);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      cmd.pen_mode = PEN_ZERO;
      case (state_ff)
         ST_LOAD: begin
            if (accept) begin
               cmd.store_write = 1'b1;
               if (req_last_price) begin
                  cmd.pass_start = 1'b1;
                  cmd.pen_mode   = PEN_ZERO;
                  state_in       = ST_WAIT_ZERO;
               end
            end
         end
         ST_WAIT_ZERO: begin
            if (status.pass_done) begin
               if (status.fits) begin
                  cmd.result_zero = 1'b1;
                  cmd.count_clear = 1'b1;
                  rsp_valid_in    = 1'b1;
                  state_in        = ST_LOAD;
               end else begin
                  cmd.search_init = 1'b1;
                  state_in        = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            cmd.pass_start = 1'b1;
            if (status.search_open) begin
               cmd.pen_mode = PEN_MID;
               state_in     = ST_WAIT_MID;
            end else begin
               cmd.pen_mode = PEN_LOW;
               state_in     = ST_WAIT_LOW;
            end
         end
         ST_WAIT_MID: begin
            if (status.pass_done) begin
               cmd.bound_update = 1'b1;
               state_in         = ST_CHECK;
            end
         end
         ST_WAIT_LOW: begin
            if (status.pass_done) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            cmd.sum         = 1'b1;
            cmd.count_clear = 1'b1;
            rsp_valid_in    = 1'b1;
            state_in        = ST_LOAD;
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

endmodule

`default_nettype wire

### rtl/mptk_dpath.sv
// Price store, streaming DP pass, penalty search bounds and result arithmetic.
`default_nettype none

module mptk_dpath
   import mptk_pkg::*;
#(
   parameter int MAX_PRICES  = 1024,
   parameter int PENALTY_MAX = 10000000
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic [PRICE_W-1:0]  req_price,
   input  wire logic                csr_write,
   input  wire logic [TRADES_W-1:0] csr_max_trades,
   input  wire cmd_type             cmd,
   output status_type               status,
   output logic [PROFIT_W-1:0]      rsp_best_profit
);

   localparam int AW    = (MAX_PRICES > 1) ? $clog2(MAX_PRICES) : 1;
   localparam int CNTW  = $clog2(MAX_PRICES + 1);
   localparam int TW    = CNTW;
   localparam int CMPW  = (TW > TRADES_W) ? TW : TRADES_W;
   localparam int MULW  = TRADES_W + PRICE_W;

   typedef logic signed [VALUE_W-1:0] value_type;

   logic [PRICE_W-1:0]  mem [MAX_PRICES];

   logic [CNTW-1:0]     count_ff;
   logic [TRADES_W-1:0] k_ff;
   logic [PRICE_W-1:0]  low_ff, high_ff, pen_ff;
   logic [PRICE_W:0]    mid_sum;
   logic [PRICE_W-1:0]  mid;

   logic [AW-1:0]       idx_ff;
   logic                issue_ff;
   logic                issue_last;

   logic [PRICE_W-1:0]  rdata_ff;
   logic                s1_valid_ff, s1_first_ff, s1_last_ff;
   logic [PRICE_W-1:0]  px_ff;
   value_type           pxm_ff;
   logic                s2_valid_ff, s2_first_ff, s2_last_ff;
   logic                done_ff;

   value_type           free_ff, hold_ff;
   logic [TW-1:0]       ft_ff, ht_ff;
   value_type           free_in, hold_in;
   logic [TW-1:0]       ft_in, ht_in;
   value_type           sell, buy, total;
   logic [TW-1:0]       sell_t;

   logic [MULW-1:0]     prod_ff;
   logic [PROFIT_W-1:0] result_ff;

   assign mid_sum = {1'b0, low_ff} + {1'b0, high_ff};
   assign mid     = mid_sum[PRICE_W:1];

   assign issue_last = (CNTW'(idx_ff) == count_ff - CNTW'(1));

   // Store write port and registered read port.
   always_ff @(posedge clock) begin
      if (cmd.store_write && (count_ff < CNTW'(MAX_PRICES))) begin
         mem[count_ff[AW-1:0]] <= req_price;
      end
      rdata_ff <= mem[idx_ff];
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         k_ff        <= TRADES_W'(1);
         low_ff      <= '0;
         high_ff     <= PRICE_W'(PENALTY_MAX);
         issue_ff    <= 1'b0;
         idx_ff      <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         done_ff     <= 1'b0;
      end else begin
         if (csr_write) begin
            k_ff <= csr_max_trades;
         end
         if (cmd.count_clear) begin
            count_ff <= '0;
         end else if (cmd.store_write && (count_ff < CNTW'(MAX_PRICES))) begin
            count_ff <= count_ff + CNTW'(1);
         end
         if (cmd.search_init) begin
            low_ff  <= '0;
            high_ff <= PRICE_W'(PENALTY_MAX);
         end else if (cmd.bound_update) begin
            if (status.fits) begin
               high_ff <= mid;
            end else begin
               low_ff <= mid + PRICE_W'(1);
            end
         end
         if (cmd.pass_start) begin
            issue_ff <= 1'b1;
            idx_ff   <= '0;
         end else if (issue_ff) begin
            if (issue_last) begin
               issue_ff <= 1'b0;
            end else begin
               idx_ff <= idx_ff + AW'(1);
            end
         end
         s1_valid_ff <= issue_ff;
         s2_valid_ff <= s1_valid_ff;
         done_ff     <= s2_valid_ff && s2_last_ff;
      end
   end

   // Penalty chosen for the pass and pipeline side data.
   always_ff @(posedge clock) begin
      if (cmd.pass_start) begin
         case (cmd.pen_mode)
            PEN_ZERO: pen_ff <= '0;
            PEN_MID:  pen_ff <= mid;
            PEN_LOW:  pen_ff <= low_ff;
            default:  pen_ff <= '0;
         endcase
      end
      s1_first_ff <= (idx_ff == '0);
      s1_last_ff  <= issue_last;
      s2_first_ff <= s1_first_ff;
      s2_last_ff  <= s1_last_ff;
      px_ff       <= rdata_ff;
      // Price less penalty is formed ahead so that the sale is a single add.
      pxm_ff      <= $signed({{(VALUE_W - PRICE_W){1'b0}}, rdata_ff})
                   - $signed({{(VALUE_W - PRICE_W){1'b0}}, pen_ff});
   end

   // One DP step per price.
   always_comb begin
      sell   = hold_ff + pxm_ff;
      sell_t = ht_ff + TW'(1);
      buy    = free_ff - $signed({{(VALUE_W - PRICE_W){1'b0}}, px_ff});

      if (free_ff > sell) begin
         free_in = free_ff;
         ft_in   = ft_ff;
      end else if (free_ff < sell) begin
         free_in = sell;
         ft_in   = sell_t;
      end else begin
         free_in = free_ff;
         ft_in   = (ft_ff < sell_t) ? ft_ff : sell_t;
      end

      if (buy > hold_ff) begin
         hold_in = buy;
         ht_in   = ft_ff;
      end else if (buy < hold_ff) begin
         hold_in = hold_ff;
         ht_in   = ht_ff;
      end else begin
         hold_in = hold_ff;
         ht_in   = (ft_ff < ht_ff) ? ft_ff : ht_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_valid_ff) begin
         if (s2_first_ff) begin
            free_ff <= '0;
            ft_ff   <= '0;
            hold_ff <= -$signed({{(VALUE_W - PRICE_W){1'b0}}, px_ff});
            ht_ff   <= '0;
         end else begin
            free_ff <= free_in;
            ft_ff   <= ft_in;
            hold_ff <= hold_in;
            ht_ff   <= ht_in;
         end
      end
   end

   // Result arithmetic: multiply into a register, then add and clamp.
   assign total = free_ff + $signed({{(VALUE_W - MULW){1'b0}}, prod_ff});

   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         prod_ff <= MULW'(k_ff) * MULW'(pen_ff);
      end
      if (cmd.result_zero) begin
         result_ff <= free_ff[PROFIT_W-1:0];
      end else if (cmd.sum) begin
         result_ff <= total[VALUE_W-1] ? '0 : total[PROFIT_W-1:0];
      end
   end

   assign status.pass_done   = done_ff;
   assign status.fits        = (CMPW'(ft_ff) <= CMPW'(k_ff));
   assign status.search_open = (low_ff < high_ff);
   assign rsp_best_profit    = result_ff;

endmodule

`default_nettype wire

### dv/max_profit_checker.sv
// Watches the ports of the k-trade profit block, predicts every profit and compares the results.
`timescale 1ns / 1ps

module max_profit_checker
   import mptk_pkg::*;
#(
   parameter int MAX_PRICES  = 1024,
   parameter int PENALTY_MAX = 10000000
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   input  wire logic                req_ready,
   input  wire logic [PRICE_W-1:0]  req_price,
   input  wire logic                req_last_price,
   input  wire logic                rsp_valid,
   input  wire logic                rsp_ready,
   input  wire logic [PROFIT_W-1:0] rsp_best_profit,
   input  wire logic                csr_valid,
   input  wire logic                csr_ready,
   input  wire logic [TRADES_W-1:0] csr_max_trades,
   output int                       failures,
   output int                       outstanding,
   output int                       profits_seen
);

   typedef logic signed [VALUE_W-1:0] dp_value_type;
   typedef logic [TRADES_W-1:0]       trades_type;

   logic [PRICE_W-1:0]  series [MAX_PRICES];
   int                  series_len;
   trades_type          trade_limit;
   logic [PROFIT_W-1:0] pending_profits [$];
   int                  fail_count;
   int                  seen_count;

   // One walk over the series with a fixed cost per sale. Equal values keep the
   // smaller trade count.
   task automatic penalised_pass(input dp_value_type pen, output dp_value_type free_v,
                                 output trades_type free_t);
      dp_value_type hold_v;
      trades_type   hold_t;
      dp_value_type px;
      dp_value_type sell;
      dp_value_type buy;
      dp_value_type next_free_v;
      dp_value_type next_hold_v;
      trades_type   sell_t;
      trades_type   next_free_t;
      trades_type   next_hold_t;
      free_v = '0;
      free_t = '0;
      hold_v = -dp_value_type'(series[0]);
      hold_t = '0;
      for (int i = 1; i < series_len; i++) begin
         px     = dp_value_type'(series[i]);
         sell   = hold_v + px - pen;
         sell_t = hold_t + 1'b1;
         buy    = free_v - px;
         if (free_v > sell) begin
            next_free_v = free_v;
            next_free_t = free_t;
         end else if (free_v < sell) begin
            next_free_v = sell;
            next_free_t = sell_t;
         end else begin
            next_free_v = free_v;
            next_free_t = (free_t < sell_t) ? free_t : sell_t;
         end
         if (buy > hold_v) begin
            next_hold_v = buy;
            next_hold_t = free_t;
         end else if (buy < hold_v) begin
            next_hold_v = hold_v;
            next_hold_t = hold_t;
         end else begin
            next_hold_v = hold_v;
            next_hold_t = (free_t < hold_t) ? free_t : hold_t;
         end
         free_v = next_free_v;
         free_t = next_free_t;
         hold_v = next_hold_v;
         hold_t = next_hold_t;
      end
   endtask

   task automatic solve_best_profit(output logic [PROFIT_W-1:0] profit);
      dp_value_type free_v;
      dp_value_type total;
      trades_type   free_t;
      int           pen_lo;
      int           pen_hi;
      int           pen_mid;
      penalised_pass('0, free_v, free_t);
      if (free_t <= trade_limit) begin
         profit = free_v[PROFIT_W-1:0];
      end else begin
         // Least penalty whose trade count fits; stops at the top of the range.
         pen_lo = 0;
         pen_hi = PENALTY_MAX;
         while (pen_lo < pen_hi) begin
            pen_mid = (pen_lo + pen_hi) / 2;
            penalised_pass(dp_value_type'(pen_mid), free_v, free_t);
            if (free_t <= trade_limit)
               pen_hi = pen_mid;
            else
               pen_lo = pen_mid + 1;
         end
         penalised_pass(dp_value_type'(pen_lo), free_v, free_t);
         total = free_v + dp_value_type'(trade_limit) * dp_value_type'(pen_lo);
         if (total < 0)
            total = '0;
         profit = total[PROFIT_W-1:0];
      end
   endtask

   always @(posedge clock) begin
      logic [PROFIT_W-1:0] profit;
      logic [PROFIT_W-1:0] wanted;
      if (reset) begin
         series_len  = 0;
         trade_limit = 1;
         fail_count  = 0;
         seen_count  = 0;
         pending_profits.delete();
      end else begin
         if (csr_valid && csr_ready)
            trade_limit = csr_max_trades;
         if (req_valid && req_ready) begin
            // A full store drops the price, but a last flag still closes the series.
            if (series_len < MAX_PRICES) begin
               series[series_len] = req_price;
               series_len++;
            end
            if (req_last_price) begin
               solve_best_profit(profit);
               pending_profits.push_back(profit);
               series_len = 0;
            end
         end
         if (rsp_valid && rsp_ready) begin
            seen_count++;
            if (pending_profits.size() == 0) begin
               $error("best_profit with no item waiting: expected none, actual %0d",
                      rsp_best_profit);
               fail_count++;
            end else begin
               wanted = pending_profits.pop_front();
               if (rsp_best_profit !== wanted) begin
                  $error("best_profit mismatch: expected %0d, actual %0d",
                         wanted, rsp_best_profit);
                  fail_count++;
               end
            end
         end
      end
      failures     <= fail_count;
      outstanding  <= pending_profits.size();
      profits_seen <= seen_count;
   end

endmodule

### dv/max_profit_k_trades_tb.sv
// Stimulus and verdict for the k-trade maximum profit block.
`timescale 1ns / 1ps

module max_profit_k_trades_tb;
   import mptk_pkg::*;

   localparam int     MAX_PRICES    = 1024;
   localparam int     PENALTY_MAX   = 10000000;
   localparam int     HOLD_CYCLES   = 2000;
   localparam int     SETTLE_CYCLES = 64;
   localparam int     FULL_SERIES   = MAX_PRICES + 6;
   localparam int     BATCH_ITEMS   = 8;
   localparam longint TIMEOUT_NS    = 64'd16_000_000;

   typedef enum int {PX_FULL, PX_NARROW, PX_ZIGZAG, PX_EXTREME} price_style_type;

   logic                clock          = 1'b0;
   logic                reset          = 1'b1;
   logic                req_valid      = 1'b0;
   logic [PRICE_W-1:0]  req_price      = '0;
   logic                req_last_price = 1'b0;
   logic                rsp_ready      = 1'b0;
   logic                csr_valid      = 1'b0;
   logic [TRADES_W-1:0] csr_max_trades = '0;
   wire                 req_ready;
   wire                 rsp_valid;
   wire [PROFIT_W-1:0]  rsp_best_profit;
   wire                 csr_ready;

   int   failures;
   int   outstanding;
   int   profits_seen;
   int   send_idle_pct = 0;
   int   rsp_stall_pct = 0;
   logic long_hold     = 1'b0;
   int   hold_count    = 0;
   int   items_sent    = 0;
   int   series_sent   = 0;

   always #2 clock = ~clock;

   max_profit_k_trades #(
      .MAX_PRICES (MAX_PRICES),
      .PENALTY_MAX(PENALTY_MAX)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_price      (req_price),
      .req_last_price (req_last_price),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_best_profit(rsp_best_profit),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_max_trades (csr_max_trades)
   );

   max_profit_checker #(
      .MAX_PRICES (MAX_PRICES),
      .PENALTY_MAX(PENALTY_MAX)
   ) checker_i (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_price      (req_price),
      .req_last_price (req_last_price),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_best_profit(rsp_best_profit),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_max_trades (csr_max_trades),
      .failures       (failures),
      .outstanding    (outstanding),
      .profits_seen   (profits_seen)
   );

   // Result side: random stalls, or a long hold-off while long_hold is up.
   always @(posedge clock) begin
      if (long_hold && hold_count < HOLD_CYCLES) begin
         rsp_ready  <= 1'b0;
         hold_count <= hold_count + 1;
      end else begin
         if (!long_hold)
            hold_count <= 0;
         rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
      end
   end

   initial begin
      #(TIMEOUT_NS);
      $display("Regression FAIL");
      $finish;
   end

   function automatic int pick_gap();
      int n;
      n = 0;
      while (n < 60 && $urandom_range(0, 99) < send_idle_pct)
         n++;
      return n;
   endfunction

   function automatic logic [TRADES_W-1:0] pick_trade_limit();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return TRADES_W'(1024);
         2, 3:    return TRADES_W'($urandom_range(0, 1024));
         default: return TRADES_W'($urandom_range(1, 4));
      endcase
   endfunction

   function automatic int pick_series_len();
      case ($urandom_range(0, 19))
         0:       return 1;
         1:       return $urandom_range(17, 64);
         default: return $urandom_range(2, 16);
      endcase
   endfunction

   task automatic offer_price(input logic [PRICE_W-1:0] px, input logic last);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_price      <= px;
      req_last_price <= last;
      do @(posedge clock); while (!req_ready);
      items_sent++;
      if (last)
         series_sent++;
   endtask

   task automatic send_series(input int len, input price_style_type style);
      logic [PRICE_W-1:0] px;
      logic [PRICE_W-1:0] amp;
      case ($urandom_range(0, 3))
         0:       amp = 24'd15;
         1:       amp = 24'd100000;
         2:       amp = 24'd9000000;
         default: amp = 24'hFFFFFF - 24'd255;
      endcase
      for (int i = 0; i < len; i++) begin
         case (style)
            PX_FULL:   px = PRICE_W'($urandom());
            PX_NARROW: px = PRICE_W'($urandom_range(0, 7));
            PX_ZIGZAG: begin
               px = PRICE_W'($urandom_range(0, 255));
               if (i % 2 == 1)
                  px = px + PRICE_W'($urandom_range(0, amp));
            end
            default:   px = $urandom_range(0, 1) ? 24'hFFFFFF : 24'h000000;
         endcase
         offer_price(px, i == len - 1);
      end
   endtask

   task automatic send_random_batch(input int budget);
      int len;
      while (budget > 0) begin
         len = pick_series_len();
         send_series(len, price_style_type'($urandom_range(0, 3)));
         budget -= len;
      end
   endtask

   // Waits until every predicted profit has been taken, then lets the block settle.
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_trade_limit(input logic [TRADES_W-1:0] limit);
      csr_valid      <= 1'b1;
      csr_max_trades <= limit;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed items, with the reset limit of one trade first.
      offer_price(24'd0, 1'b1);
      offer_price(24'd0, 1'b0);      offer_price(24'hFFFFFF, 1'b1);
      offer_price(24'hFFFFFF, 1'b0); offer_price(24'd0, 1'b1);
      offer_price(24'd5, 1'b0);      offer_price(24'd5, 1'b0);
      offer_price(24'd5, 1'b0);      offer_price(24'd5, 1'b1);
      offer_price(24'd1, 1'b0);      offer_price(24'd9, 1'b0);
      offer_price(24'd1, 1'b0);      offer_price(24'd9, 1'b0);
      offer_price(24'd1, 1'b0);      offer_price(24'd9, 1'b1);
      drain();
      // With no trades allowed, even the top penalty leaves a trade here.
      write_trade_limit('0);
      offer_price(24'd0, 1'b0);      offer_price(24'hFFFFFF, 1'b1);
      offer_price(24'd3, 1'b0);      offer_price(24'd8, 1'b1);
      drain();
      write_trade_limit(TRADES_W'(1024));
      offer_price(24'd3, 1'b0);      offer_price(24'd7, 1'b0);
      offer_price(24'd2, 1'b0);      offer_price(24'd9, 1'b0);
      offer_price(24'd0, 1'b0);      offer_price(24'hFFFFFF, 1'b1);
      drain();

      for (int round = 0; round < 2; round++) begin
         for (int mode = 0; mode < 4; mode++) begin
            case (mode)
               0: begin send_idle_pct = 0;  rsp_stall_pct <= 0;  end
               1: begin send_idle_pct = 83; rsp_stall_pct <= 0;  end
               2: begin send_idle_pct = 0;  rsp_stall_pct <= 83; end
               default: begin send_idle_pct = 8; rsp_stall_pct <= 8; end
            endcase
            for (int batch = 0; batch < 5; batch++) begin
               write_trade_limit(pick_trade_limit());
               send_random_batch(BATCH_ITEMS);
               drain();
            end
         end
      end

      // Long hold-off on results while several series keep arriving.
      send_idle_pct = 0;
      rsp_stall_pct <= 0;
      write_trade_limit(pick_trade_limit());
      long_hold <= 1'b1;
      for (int s = 0; s < 5; s++)
         send_series($urandom_range(3, 12), price_style_type'($urandom_range(0, 3)));
      drain();
      long_hold <= 1'b0;

      // One series past the store size; its last item is among the dropped ones.
      send_idle_pct = 8;
      rsp_stall_pct <= 8;
      write_trade_limit(TRADES_W'($urandom_range(1, 6)));
      send_series(FULL_SERIES, PX_FULL);
      drain();

      $display("Covered %0d items in %0d series, %0d profits checked, trade limits 0 to 1024.",
               items_sent, series_sent, profits_seen);
      $display("Ran free-flowing, idle sender, stalling receiver, long hold-off and a full store.");
      if (failures == 0 && outstanding == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
